>>> design/sfcb_pkg.sv
`timescale 1ns / 1ps
package sfcb_pkg;

   localparam int MAX_SYMBOLS = 64;
   localparam int COUNT_WIDTH = 16;
   localparam int IDX_W       = $clog2(MAX_SYMBOLS);
   localparam int NUM_W       = IDX_W + 1;
   localparam int TOT_W       = COUNT_WIDTH + IDX_W + 2;
   localparam int CODE_W      = 63;
   localparam int LEN_W       = 6;
   localparam int SYM_W       = 8;
   localparam int OCNT_W      = 16;

   typedef enum logic [4:0] {
      ST_IDLE, ST_C_RD, ST_C_CMP, ST_NEW, ST_FIN,
      ST_SEL_RD, ST_SEL_CMP, ST_SEL_WR, ST_STK_INIT,
      ST_POP_RD, ST_POP_LD, ST_TOT_RD, ST_TOT_ACC, ST_G_INIT, ST_G_RD, ST_G_EV,
      ST_AP_RD, ST_AP_WR, ST_PUSH_HI, ST_PUSH_LO,
      ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT
   } state_type;

   typedef enum logic [2:0] {
      SU_HOLD, SU_CLR, SU_TOT, SU_INIT, SU_STEP
   } su_op_type;

   typedef struct packed {
      logic cont;    // 2*sum <= total
      logic better;  // adding the offered count lowers |total - 2*sum|
   } su_stat_type;

   function automatic logic [OCNT_W-1:0] low_count(input logic [COUNT_WIDTH-1:0] c);
      logic [31:0] t;
      t = 32'(c);
      return t[OCNT_W-1:0];
   endfunction

endpackage

>>> design/sfcb_ram.sv
`timescale 1ns / 1ps
module sfcb_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> design/sfcb_split_unit.sv
`timescale 1ns / 1ps
module sfcb_split_unit import sfcb_pkg::*; (
   input  logic                   clock,
   input  su_op_type              op,
   input  logic [COUNT_WIDTH-1:0] cnt,
   output su_stat_type            stat
);
   logic [TOT_W-1:0] total_ff, total_in;
   logic [TOT_W-1:0] sum_ff, sum_in;
   logic [TOT_W-1:0] best_ff, best_in;
   logic [TOT_W-1:0] sum_nx, sum2, diff;

   always_comb begin
      sum_nx = sum_ff + TOT_W'(cnt);
      sum2   = {sum_nx[TOT_W-2:0], 1'b0};
      diff   = (total_ff >= sum2) ? total_ff - sum2 : sum2 - total_ff;
      stat.cont   = ({sum_ff[TOT_W-2:0], 1'b0} <= total_ff);
      stat.better = (diff < best_ff);
      total_in = total_ff;
      sum_in   = sum_ff;
      best_in  = best_ff;
      unique case (op)
         SU_CLR: begin
            total_in = '0;
            sum_in   = '0;
         end
         SU_TOT:  total_in = total_ff + TOT_W'(cnt);
         SU_INIT: begin
            best_in = total_ff;
            sum_in  = '0;
         end
         SU_STEP: begin
            sum_in  = sum_nx;
            best_in = diff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      sum_ff   <= sum_in;
      best_ff  <= best_in;
   end
endmodule

>>> design/shannon_fano_code_builder_core.sv
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                          | tuser      | tlast
// req_    | in  | symbol[7:0]                                 | -          | last
// rsp_    | out | out_symbol, code_bits, code_length,         | error_flag | last_entry
//         |     | symbol_count, 3 zero bits (96 bits)         |            |
// Each byte is compared against the held symbols one by one; the table search
// shares one compare over the count memory.
// After the last byte: a selection sort, then per range a pass for the total,
// the split walk and a pass for code append (one RAM port).
// Each result is read, loaded and held until taken; no request is taken meanwhile.
// Reset is synchronous and clears the symbol count and error flag.
module shannon_fano_code_builder_core import sfcb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // symbol
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // out_symbol, code_bits, code_length, symbol_count
   output logic        rsp_tuser,   // error_flag
   output logic        rsp_tlast
);
   localparam int RAW_W  = SYM_W + COUNT_WIDTH;
   localparam int CODE_E = CODE_W + LEN_W;
   localparam int STK_W  = 2 * NUM_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [NUM_W-1:0] N_MAX = NUM_W'(MAX_SYMBOLS);

   state_type state_ff, state_in;
   logic [NUM_W-1:0] idx_ff, idx_in, pos_ff, pos_in, used_ff, used_in, sp_ff, sp_in;
   logic [NUM_W-1:0] lo_ff, lo_in, hi_ff, hi_in, split_ff, split_in;
   logic             ovf_ff, ovf_in, last_ff, last_in, found_ff, found_in;
   logic [SYM_W-1:0] sym_ff, sym_in, bsym_ff, bsym_in;
   logic [COUNT_WIDTH-1:0] bcnt_ff, bcnt_in;
   logic [IDX_W-1:0] bidx_ff, bidx_in;
   logic [MAX_SYMBOLS-1:0] taken_ff, taken_in;
   logic             rv_ff, rv_in;
   logic [95:0]      rd_ff, rd_in;
   logic             ru_ff, ru_in, rl_ff, rl_in;

   logic             raw_we, srt_we, code_we, stk_we;
   logic [IDX_W-1:0] raw_wa, raw_ra, srt_wa, srt_ra, code_wa, code_ra, stk_wa, stk_ra;
   logic [RAW_W-1:0] raw_wd, raw_rd, srt_wd, srt_rd;
   logic [CODE_E-1:0] code_wd, code_rd;
   logic [STK_W-1:0] stk_wd, stk_rd;
   su_op_type        su_op;
   su_stat_type      su_stat;
   logic [COUNT_WIDTH-1:0] raw_cnt, srt_cnt;
   logic [CODE_W-1:0] cur_code;
   logic [LEN_W-1:0]  cur_len;
   logic              bit_v;

   sfcb_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(RAW_W)) u_raw (
      .clock, .wr_en(raw_we), .wr_addr(raw_wa), .wr_data(raw_wd),
      .rd_addr(raw_ra), .rd_data(raw_rd));
   sfcb_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(RAW_W)) u_srt (
      .clock, .wr_en(srt_we), .wr_addr(srt_wa), .wr_data(srt_wd),
      .rd_addr(srt_ra), .rd_data(srt_rd));
   sfcb_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(CODE_E)) u_code (
      .clock, .wr_en(code_we), .wr_addr(code_wa), .wr_data(code_wd),
      .rd_addr(code_ra), .rd_data(code_rd));
   sfcb_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(STK_W)) u_stk (
      .clock, .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_addr(stk_ra), .rd_data(stk_rd));

   sfcb_split_unit u_split (.clock, .op(su_op), .cnt(srt_cnt), .stat(su_stat));

   assign raw_cnt  = raw_rd[COUNT_WIDTH-1:0];
   assign srt_cnt  = srt_rd[COUNT_WIDTH-1:0];
   assign cur_code = code_rd[CODE_W-1:0];
   assign cur_len  = code_rd[CODE_E-1:CODE_W];
   assign bit_v    = (idx_ff >= split_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tuser  = ru_ff;
   assign rsp_tlast  = rl_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff; pos_in = pos_ff; used_in = used_ff; sp_in = sp_ff;
      lo_in = lo_ff; hi_in = hi_ff; split_in = split_ff;
      ovf_in = ovf_ff; last_in = last_ff; found_in = found_ff;
      sym_in = sym_ff; bsym_in = bsym_ff; bcnt_in = bcnt_ff; bidx_in = bidx_ff;
      taken_in = taken_ff;
      rv_in = rv_ff; rd_in = rd_ff; ru_in = ru_ff; rl_in = rl_ff;
      raw_we = 1'b0; raw_wa = idx_ff[IDX_W-1:0]; raw_wd = '0;
      raw_ra = idx_ff[IDX_W-1:0];
      srt_we = 1'b0; srt_wa = pos_ff[IDX_W-1:0]; srt_wd = {bsym_ff, bcnt_ff};
      srt_ra = idx_ff[IDX_W-1:0];
      code_we = 1'b0; code_wa = pos_ff[IDX_W-1:0]; code_wd = '0;
      code_ra = idx_ff[IDX_W-1:0];
      stk_we = 1'b0; stk_wa = sp_ff[IDX_W-1:0]; stk_wd = {split_ff, hi_ff};
      stk_ra = IDX_W'(sp_ff - 1'b1);
      su_op = SU_HOLD;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sym_in  = req_tdata;
               last_in = req_tlast;
               idx_in  = '0;
               state_in = (used_ff == '0) ? ST_NEW : ST_C_RD;
            end
         end
         ST_C_RD: state_in = ST_C_CMP;
         ST_C_CMP: begin
            if (raw_rd[RAW_W-1:COUNT_WIDTH] == sym_ff) begin
               if (raw_cnt == COUNT_MAX) begin
                  ovf_in = 1'b1;
               end else begin
                  raw_we = 1'b1;
                  raw_wd = {sym_ff, raw_cnt + 1'b1};
               end
               state_in = ST_FIN;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = (idx_ff + 1'b1 == used_ff) ? ST_NEW : ST_C_RD;
            end
         end
         ST_NEW: begin
            if (used_ff < N_MAX) begin
               raw_we  = 1'b1;
               raw_wa  = used_ff[IDX_W-1:0];
               raw_wd  = {sym_ff, COUNT_WIDTH'(1)};
               used_in = used_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (last_ff) begin
               pos_in = '0; idx_in = '0; found_in = 1'b0; taken_in = '0;
               state_in = ST_SEL_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SEL_RD: state_in = ST_SEL_CMP;
         ST_SEL_CMP: begin
            // strict compare keeps first appearance on ties
            if (!taken_ff[idx_ff[IDX_W-1:0]] && (!found_ff || raw_cnt > bcnt_ff)) begin
               found_in = 1'b1;
               bsym_in  = raw_rd[RAW_W-1:COUNT_WIDTH];
               bcnt_in  = raw_cnt;
               bidx_in  = idx_ff[IDX_W-1:0];
            end
            idx_in = idx_ff + 1'b1;
            state_in = (idx_ff + 1'b1 == used_ff) ? ST_SEL_WR : ST_SEL_RD;
         end
         ST_SEL_WR: begin
            srt_we  = 1'b1;
            code_we = 1'b1;
            taken_in[bidx_ff] = 1'b1;
            pos_in   = pos_ff + 1'b1;
            idx_in   = '0;
            found_in = 1'b0;
            if (pos_ff + 1'b1 == used_ff) begin
               pos_in = '0;
               state_in = (used_ff < NUM_W'(2)) ? ST_OUT_RD : ST_STK_INIT;
            end else begin
               state_in = ST_SEL_RD;
            end
         end
         ST_STK_INIT: begin
            stk_we = 1'b1;
            stk_wa = '0;
            stk_wd = {NUM_W'(0), used_ff};
            sp_in  = NUM_W'(1);
            state_in = ST_POP_RD;
         end
         ST_POP_RD: begin
            if (sp_ff == '0) begin
               pos_in = '0;
               state_in = ST_OUT_RD;
            end else begin
               sp_in = sp_ff - 1'b1;
               state_in = ST_POP_LD;
            end
         end
         ST_POP_LD: begin
            lo_in  = stk_rd[STK_W-1:NUM_W];
            hi_in  = stk_rd[NUM_W-1:0];
            idx_in = stk_rd[STK_W-1:NUM_W];
            su_op  = SU_CLR;
            state_in = (stk_rd[NUM_W-1:0] - stk_rd[STK_W-1:NUM_W] < NUM_W'(2))
                       ? ST_POP_RD : ST_TOT_RD;
         end
         ST_TOT_RD: state_in = ST_TOT_ACC;
         ST_TOT_ACC: begin
            su_op  = SU_TOT;
            idx_in = idx_ff + 1'b1;
            state_in = (idx_ff + 1'b1 == hi_ff) ? ST_G_INIT : ST_TOT_RD;
         end
         ST_G_INIT: begin
            su_op    = SU_INIT;
            split_in = lo_ff;
            state_in = ST_G_RD;
         end
         ST_G_RD: begin
            srt_ra = split_ff[IDX_W-1:0];
            if (su_stat.cont && split_ff < hi_ff) begin
               state_in = ST_G_EV;
            end else begin
               idx_in = lo_ff;
               state_in = ST_AP_RD;
            end
         end
         ST_G_EV: begin
            if (su_stat.better) begin
               su_op    = SU_STEP;
               split_in = split_ff + 1'b1;
               state_in = ST_G_RD;
            end else begin
               idx_in = lo_ff;
               state_in = ST_AP_RD;
            end
         end
         ST_AP_RD: state_in = ST_AP_WR;
         ST_AP_WR: begin
            code_we = 1'b1;
            code_wa = idx_ff[IDX_W-1:0];
            if (cur_len < LEN_W'(CODE_W)) begin
               code_wd = {cur_len + 1'b1, cur_code[CODE_W-2:0], bit_v};
            end else begin
               code_wd = code_rd;
            end
            idx_in = idx_ff + 1'b1;
            state_in = (idx_ff + 1'b1 == hi_ff) ? ST_PUSH_HI : ST_AP_RD;
         end
         ST_PUSH_HI: begin
            if (hi_ff - split_ff >= NUM_W'(2) && sp_ff < N_MAX) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + 1'b1;
            end
            state_in = ST_PUSH_LO;
         end
         ST_PUSH_LO: begin
            stk_wd = {lo_ff, split_ff};
            if (split_ff - lo_ff >= NUM_W'(2) && sp_ff < N_MAX) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + 1'b1;
            end
            state_in = ST_POP_RD;
         end
         ST_OUT_RD: begin
            srt_ra  = pos_ff[IDX_W-1:0];
            code_ra = pos_ff[IDX_W-1:0];
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            rv_in = 1'b1;
            rd_in = {3'b000, low_count(srt_cnt), cur_len, cur_code,
                     srt_rd[RAW_W-1:COUNT_WIDTH]};
            ru_in = ovf_ff;
            rl_in = (pos_ff + 1'b1 == used_ff);
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_tready) begin
               rv_in  = 1'b0;
               pos_in = pos_ff + 1'b1;
               if (rl_ff) begin
                  used_in = '0;
                  ovf_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         ovf_ff   <= 1'b0;
         sp_ff    <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         ovf_ff   <= ovf_in;
         sp_ff    <= sp_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;   pos_ff <= pos_in;
      lo_ff <= lo_in;     hi_ff <= hi_in;     split_ff <= split_in;
      last_ff <= last_in; found_ff <= found_in;
      sym_ff <= sym_in;   bsym_ff <= bsym_in; bcnt_ff <= bcnt_in; bidx_ff <= bidx_in;
      taken_ff <= taken_in;
      rd_ff <= rd_in;     ru_ff <= ru_in;     rl_ff <= rl_in;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("request taken during output");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= N_MAX) else $error("symbol count past table size");
   a_stk_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= N_MAX) else $error("range stack overrun");
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && used_ff == '0)
      else $error("block not cleared after final entry");
endmodule
